[rtl/rtc_pkg.sv]
// ----------------------------------------------------------------------------
// rtc_pkg
// Shared constants and pipeline payload types of the ranging timing budget
// calculator.
// ----------------------------------------------------------------------------
`default_nettype none
package rtc_pkg;

	localparam int unsigned MacroBits = 20;
	localparam int unsigned UsBits    = 23;
	localparam int unsigned QuotBits  = 20;
	localparam int unsigned DivStages = 5;
	localparam int unsigned DivStep   = QuotBits / DivStages;

	localparam logic [11:0] MacroWhole  = 12'd3813;
	localparam logic [6:0]  MacroFrac   = 7'd120;
	localparam logic [9:0]  MacroRound  = 10'd500;
	localparam logic [18:0] Recip1000   = 19'd268436;
	localparam logic [29:0] Recip125    = 30'd549755814;

	localparam logic [31:0] StartEndUs  = 32'd2870;
	localparam logic [31:0] SetStartUs  = 32'd2280;
	localparam logic [31:0] TccOvhUs    = 32'd590;
	localparam logic [31:0] DssOvhUs    = 32'd690;
	localparam logic [31:0] MsrcOvhUs   = 32'd660;
	localparam logic [31:0] PreOvhUs    = 32'd660;
	localparam logic [31:0] FinalOvhUs  = 32'd550;
	localparam logic [31:0] MinBudgetUs = 32'd20000;

	localparam logic [1:0] StatusOk      = 2'd0;
	localparam logic [1:0] StatusBelow   = 2'd1;
	localparam logic [1:0] StatusNoRoom  = 2'd2;

	typedef struct packed {
		logic tcc;
		logic dss;
		logic msrc;
		logic pre;
		logic fin;
	} steps_t;

	typedef struct packed {
		steps_t                 steps;
		logic [UsBits-1:0]      step_us;
		logic [UsBits-1:0]      pre_us;
		logic [UsBits-1:0]      fin_us;
		logic [15:0]            pre_clk;
		logic [MacroBits-1:0]   m_fin;
		logic [31:0]            req;
	} conv_t;

	typedef struct packed {
		logic [31:0] total;
		logic [1:0]  status;
		logic        wr;
		logic        pre;
		logic [15:0] pre_clk;
	} side_t;

endpackage
`default_nettype wire

[rtl/rtc_item_if.sv]
// ----------------------------------------------------------------------------
// rtc_item_if
// Request channel of the timing budget calculator.
// ----------------------------------------------------------------------------
`default_nettype none
interface rtc_item_if;
	logic        valid;
	logic        ready;
	logic [7:0]  step_enables;
	logic [7:0]  msrc_timeout_raw;
	logic [15:0] pre_range_timeout_code;
	logic [15:0] final_range_timeout_code;
	logic [7:0]  pre_vcsel_raw;
	logic [7:0]  final_vcsel_raw;
	logic [31:0] requested_budget_us;

	modport source (output valid, step_enables, msrc_timeout_raw,
		pre_range_timeout_code, final_range_timeout_code, pre_vcsel_raw,
		final_vcsel_raw, requested_budget_us, input ready);
	modport sink (input valid, step_enables, msrc_timeout_raw,
		pre_range_timeout_code, final_range_timeout_code, pre_vcsel_raw,
		final_vcsel_raw, requested_budget_us, output ready);
endinterface
`default_nettype wire

[rtl/rtc_result_if.sv]
// ----------------------------------------------------------------------------
// rtc_result_if
// Result channel of the timing budget calculator.
// ----------------------------------------------------------------------------
`default_nettype none
interface rtc_result_if;
	logic        valid;
	logic        ready;
	logic [31:0] current_budget_us;
	logic [15:0] new_final_code;
	logic        write_final;
	logic [1:0]  set_status;

	modport source (output valid, current_budget_us, new_final_code, write_final,
		set_status, input ready);
	modport sink (input valid, current_budget_us, new_final_code, write_final,
		set_status, output ready);
endinterface
`default_nettype wire

[rtl/ranging_timing_budget_calc.sv]
// ----------------------------------------------------------------------------
// ranging_timing_budget_calc
// Timing budget of a time-of-flight ranging sequence and the final-range
// timeout word that fits a requested budget.
// ----------------------------------------------------------------------------
// Requests arrive on the item channel (valid/ready) and carry the sequence
// step byte, the timeout bytes and words, the two period bytes and the
// requested budget. Each request gives exactly one result on the result
// channel, in order.
// A request passes through eleven register stages: three front stages (macro
// period, products, scaling to microseconds), two budget stages, five divider
// stages of four quotient bits each, and the encoding stage that loads the
// output register.
// Throughput is one request per cycle; the whole pipeline advances together.
// When the receiver stalls with a result waiting, every stage holds and item
// ready goes low; empty stages still fill while the output is free.
// Reset clears every valid bit; the data registers are not reset.
// ----------------------------------------------------------------------------
`default_nettype none
module ranging_timing_budget_calc (
	input  wire logic    clk,
	input  wire logic    arst_n,
	rtc_item_if.sink     item,
	rtc_result_if.source result
);

	logic                en;
	logic                fv;
	rtc_pkg::conv_t      fd;

	logic                v_s4, v_s5, v_q;
	rtc_pkg::steps_t     steps_s4;
	logic [31:0]         total_s4, used_s4, req_s4;
	logic [15:0]         pre_clk_s4;
	logic [rtc_pkg::MacroBits-1:0] m_fin_s4, m_fin_s5;
	logic [31:0]         num_s5;
	rtc_pkg::side_t      side_s5;

	logic                dv;
	logic [rtc_pkg::QuotBits-1:0] dq;
	logic                dz;
	rtc_pkg::side_t      dside;

	logic [31:0]         tot_c, used_c, common_c;
	logic [31:0]         step32, pre32, fin32;
	logic                below_c, noroom_c;
	logic [15:0]         clk_c, man_c, code_c;
	logic [3:0]          ex_c;
	logic [3:0]          msb_c;

	assign en         = !v_q || result.ready;
	assign item.ready = en;

	rtc_front u_front (
		.clk                      (clk),
		.arst_n                   (arst_n),
		.en                       (en),
		.in_valid                 (item.valid),
		.step_enables             (item.step_enables),
		.msrc_timeout_raw         (item.msrc_timeout_raw),
		.pre_range_timeout_code   (item.pre_range_timeout_code),
		.final_range_timeout_code (item.final_range_timeout_code),
		.pre_vcsel_raw            (item.pre_vcsel_raw),
		.final_vcsel_raw          (item.final_vcsel_raw),
		.requested_budget_us      (item.requested_budget_us),
		.out_valid                (fv),
		.out_data                 (fd)
	);

	always_comb begin
		step32   = 32'(fd.step_us);
		pre32    = 32'(fd.pre_us);
		fin32    = 32'(fd.fin_us);
		common_c = '0;
		if (fd.steps.tcc) begin
			common_c = common_c + step32 + rtc_pkg::TccOvhUs;
		end
		if (fd.steps.dss) begin
			common_c = common_c + ((step32 + rtc_pkg::DssOvhUs) << 1);
		end else if (fd.steps.msrc) begin
			common_c = common_c + step32 + rtc_pkg::MsrcOvhUs;
		end
		if (fd.steps.pre) begin
			common_c = common_c + pre32 + rtc_pkg::PreOvhUs;
		end
		used_c = common_c + rtc_pkg::SetStartUs;
		tot_c  = common_c + rtc_pkg::StartEndUs;
		if (fd.steps.fin) begin
			used_c = used_c + rtc_pkg::FinalOvhUs;
			tot_c  = tot_c + fin32 + rtc_pkg::FinalOvhUs;
		end
	end

	assign below_c  = req_s4 < rtc_pkg::MinBudgetUs;
	assign noroom_c = used_s4 > req_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s4 <= fv;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			steps_s4   <= fd.steps;
			total_s4   <= tot_c;
			used_s4    <= used_c;
			req_s4     <= fd.req;
			pre_clk_s4 <= fd.pre_clk;
			m_fin_s4   <= fd.m_fin;

			m_fin_s5        <= m_fin_s4;
			num_s5          <= 32'((req_s4 - used_s4) * 32'd1000) + 32'(m_fin_s4 >> 1);
			side_s5.total   <= total_s4;
			side_s5.pre     <= steps_s4.pre;
			side_s5.pre_clk <= pre_clk_s4;
			side_s5.wr      <= !below_c && steps_s4.fin && !noroom_c;
			if (below_c) begin
				side_s5.status <= rtc_pkg::StatusBelow;
			end else if (steps_s4.fin && noroom_c) begin
				side_s5.status <= rtc_pkg::StatusNoRoom;
			end else begin
				side_s5.status <= rtc_pkg::StatusOk;
			end
		end
	end

	rtc_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s5),
		.num       (num_s5),
		.den       (m_fin_s5),
		.in_side   (side_s5),
		.out_valid (dv),
		.quot      (dq),
		.den_zero  (dz),
		.out_side  (dside)
	);

	always_comb begin
		clk_c = dz ? 16'hFFFF : dq[15:0];
		if (dside.pre) begin
			clk_c = clk_c + dside.pre_clk;
		end
		man_c = clk_c - 16'd1;
		msb_c = '0;
		for (int i = 0; i < 16; i++) begin
			if (man_c[i]) begin
				msb_c = 4'(i);
			end
		end
		ex_c = (man_c[15:8] != 8'd0) ? msb_c - 4'd7 : 4'd0;
		if (clk_c == 16'd0 || !dside.wr) begin
			code_c = '0;
		end else begin
			code_c = {4'd0, ex_c, 8'(man_c >> ex_c)};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (en) begin
			v_q <= dv;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			result.current_budget_us <= dside.total;
			result.new_final_code    <= code_c;
			result.write_final       <= dside.wr;
			result.set_status        <= dside.status;
		end
	end

	assign result.valid = v_q;

`ifndef ASSERT_OFF
	a_status_code : assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> (result.set_status == rtc_pkg::StatusOk ||
			result.set_status == rtc_pkg::StatusBelow ||
			result.set_status == rtc_pkg::StatusNoRoom))
		else $error("result status out of range");
	a_write_ok : assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.write_final) |-> result.set_status == rtc_pkg::StatusOk)
		else $error("write flagged with a failing status");
	a_no_code : assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && !result.write_final) |-> result.new_final_code == 16'd0)
		else $error("timeout word given without a write");
	a_hold : assert property (@(posedge clk) disable iff (!arst_n)
		(v_q && !result.ready) |=> (result.valid && $stable(result.current_budget_us)))
		else $error("pipeline moved while the result was stalled");
`endif

endmodule
`default_nettype wire

[rtl/rtc_front.sv]
// ----------------------------------------------------------------------------
// rtc_front
// Three stages: macro periods and clock counts, clock-by-period products,
// and the scaling of the products to microseconds.
// ----------------------------------------------------------------------------
`default_nettype none
module rtc_front (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               en,
	input  wire logic               in_valid,
	input  wire logic [7:0]         step_enables,
	input  wire logic [7:0]         msrc_timeout_raw,
	input  wire logic [15:0]        pre_range_timeout_code,
	input  wire logic [15:0]        final_range_timeout_code,
	input  wire logic [7:0]         pre_vcsel_raw,
	input  wire logic [7:0]         final_vcsel_raw,
	input  wire logic [31:0]        requested_budget_us,
	output logic                    out_valid,
	output rtc_pkg::conv_t          out_data
);

	localparam int unsigned MB = rtc_pkg::MacroBits;

	function automatic logic [MB-1:0] macro_of(input logic [7:0] raw);
		logic [7:0]  p;
		logic [14:0] x;
		logic [33:0] r;
		p = {raw[6:0] + 7'd1, 1'b0};
		x = 15'(p) * 15'(rtc_pkg::MacroFrac) + 15'(rtc_pkg::MacroRound);
		r = 34'(x) * 34'(rtc_pkg::Recip1000);
		return MB'(p) * MB'(rtc_pkg::MacroWhole) + MB'(r[33:28]);
	endfunction

	function automatic logic [15:0] decode(input logic [15:0] w);
		logic [15:0] sh;
		sh = (w[15:8] < 8'd16) ? 16'(w[7:0]) << w[11:8] : 16'd0;
		return sh + 16'd1;
	endfunction

	function automatic logic [rtc_pkg::UsBits-1:0] to_us(input logic [31:0] a);
		logic [58:0] r;
		r = 59'(a[31:3]) * 59'(rtc_pkg::Recip125);
		return r[58:36];
	endfunction

	logic            v_s1, v_s2, v_s3;
	rtc_pkg::steps_t steps_s1, steps_s2;
	logic [MB-1:0]   m_pre_s1, m_fin_s1, m_pre_s2, m_fin_s2;
	logic [8:0]      step_clk_s1;
	logic [15:0]     pre_clk_s1, fin_clk_s1, pre_clk_s2;
	logic [31:0]     req_s1, req_s2;
	logic [31:0]     a_step_s2, a_pre_s2, a_fin_s2;
	logic [15:0]     pre_dec, fin_dec;

	assign pre_dec = decode(pre_range_timeout_code);
	assign fin_dec = decode(final_range_timeout_code);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			steps_s1.tcc  <= step_enables[4];
			steps_s1.dss  <= step_enables[3];
			steps_s1.msrc <= step_enables[2];
			steps_s1.pre  <= step_enables[6];
			steps_s1.fin  <= step_enables[7];
			m_pre_s1      <= macro_of(pre_vcsel_raw);
			m_fin_s1      <= macro_of(final_vcsel_raw);
			step_clk_s1   <= 9'(msrc_timeout_raw) + 9'd1;
			pre_clk_s1    <= pre_dec;
			fin_clk_s1    <= step_enables[6] ? fin_dec - pre_dec : fin_dec;
			req_s1        <= requested_budget_us;

			steps_s2  <= steps_s1;
			m_pre_s2  <= m_pre_s1;
			m_fin_s2  <= m_fin_s1;
			pre_clk_s2 <= pre_clk_s1;
			req_s2    <= req_s1;
			a_step_s2 <= 32'(32'(step_clk_s1) * 32'(m_pre_s1)) + 32'(m_pre_s1 >> 1);
			a_pre_s2  <= 32'(36'(pre_clk_s1) * 36'(m_pre_s1)) + 32'(m_pre_s1 >> 1);
			a_fin_s2  <= 32'(36'(fin_clk_s1) * 36'(m_fin_s1)) + 32'(m_fin_s1 >> 1);

			out_data.steps   <= steps_s2;
			out_data.step_us <= to_us(a_step_s2);
			out_data.pre_us  <= to_us(a_pre_s2);
			out_data.fin_us  <= to_us(a_fin_s2);
			out_data.pre_clk <= pre_clk_s2;
			out_data.m_fin   <= m_fin_s2;
			out_data.req     <= req_s2;
		end
	end

	assign out_valid = v_s3;

endmodule
`default_nettype wire

[rtl/rtc_div.sv]
// ----------------------------------------------------------------------------
// rtc_div
// Pipelined restoring divider: DivStep quotient bits per stage, side data
// carried alongside.
// ----------------------------------------------------------------------------
`default_nettype none
module rtc_div (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               en,
	input  wire logic                               in_valid,
	input  wire logic [31:0]                        num,
	input  wire logic [rtc_pkg::MacroBits-1:0]      den,
	input  wire rtc_pkg::side_t                     in_side,
	output logic                                    out_valid,
	output logic [rtc_pkg::QuotBits-1:0]            quot,
	output logic                                    den_zero,
	output rtc_pkg::side_t                          out_side
);

	localparam int unsigned NS = rtc_pkg::DivStages;
	localparam int unsigned NB = rtc_pkg::DivStep;
	localparam int unsigned QB = rtc_pkg::QuotBits;
	localparam int unsigned MB = rtc_pkg::MacroBits;

	logic [NS:0]         v;
	logic [31:0]         rem   [NS+1];
	logic [QB-1:0]       q     [NS+1];
	logic [MB-1:0]       d     [NS+1];
	rtc_pkg::side_t      side  [NS+1];

	assign v[0]    = in_valid;
	assign rem[0]  = num;
	assign q[0]    = '0;
	assign d[0]    = den;
	assign side[0] = in_side;

	for (genvar g = 0; g < NS; g++) begin : g_stage
		logic [31:0]   rem_n;
		logic [QB-1:0] q_n;

		always_comb begin
			logic [31+MB:0] sub;
			rem_n = rem[g];
			q_n   = q[g];
			for (int j = 0; j < NB; j++) begin
				sub = (32+MB)'(d[g]) << (QB - 1 - g * NB - j);
				if ((32+MB)'(rem_n) >= sub) begin
					rem_n = rem_n - sub[31:0];
					q_n[QB - 1 - g * NB - j] = 1'b1;
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v[g+1] <= 1'b0;
			end else if (en) begin
				v[g+1] <= v[g];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem[g+1]  <= rem_n;
				q[g+1]    <= q_n;
				d[g+1]    <= d[g];
				side[g+1] <= side[g];
			end
		end
	end

	assign out_valid = v[NS];
	assign quot      = q[NS];
	assign den_zero  = (d[NS] == '0);
	assign out_side  = side[NS];

endmodule
`default_nettype wire

[sim/tb_budget_if_note.sv]
// ----------------------------------------------------------------------------
// tb_budget_types
// Request and result records used by the timing budget testbench.
// ----------------------------------------------------------------------------
package tb_budget_types;

	typedef struct {
		logic [7:0]  seq;
		logic [7:0]  msrc_raw;
		logic [15:0] pre_code;
		logic [15:0] fin_code;
		logic [7:0]  pre_vcsel;
		logic [7:0]  fin_vcsel;
		logic [31:0] req;
	} budget_req_t;

	typedef struct packed {
		logic [31:0] total;
		logic [15:0] code;
		logic        wr;
		logic [1:0]  status;
	} budget_res_t;

	typedef struct {
		budget_req_t rq;
		logic        has_exp;
		budget_res_t ex;
	} budget_row_t;

endpackage

[sim/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Testbench of the ranging timing budget calculator. A table of directed
// requests, then random requests under several idle and stall phases, are sent
// through the request channel; every result is compared with a behavioral
// budget predictor, and rows with typed-in values also check those against it.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	rtc_item_if   item();
	rtc_result_if result();

	ranging_timing_budget_calc dut (
		.clk   (clk),
		.arst_n(arst_n),
		.item  (item),
		.result(result)
	);

	always #1 clk = ~clk;

	tb_budget_types::budget_res_t expected_q[$];
	tb_budget_types::budget_res_t typed_q[$];
	logic        typed_has_q[$];
	int unsigned send_idle_pct = 0;
	int unsigned recv_stall_pct = 0;
	bit          hold_off = 1'b0;
	bit          failed = 1'b0;
	int unsigned quiet_cycles = 0;

	function automatic logic [31:0] macro_ns_of(logic [31:0] period);
		return (32'd2304 * period * 32'd1655 + 32'd500) / 32'd1000;
	endfunction

	function automatic logic [31:0] pclk_period(logic [7:0] raw);
		logic [7:0] p;
		p = (raw + 8'd1) << 1;
		return {24'd0, p};
	endfunction

	function automatic logic [31:0] clk_to_us(logic [31:0] clocks, logic [31:0] period);
		logic [31:0] m;
		m = macro_ns_of(period);
		return (clocks * m + m / 32'd2) / 32'd1000;
	endfunction

	function automatic logic [31:0] us_to_clk(logic [31:0] us, logic [31:0] period);
		logic [31:0] m;
		m = macro_ns_of(period);
		if (m == 32'd0) begin
			return 32'hFFFF_FFFF;
		end
		return (us * 32'd1000 + m / 32'd2) / m;
	endfunction

	function automatic logic [15:0] timeout_clocks(logic [15:0] word);
		logic [31:0] sh;
		sh = (word[15:8] < 8'd16) ? ((32'(word[7:0]) << word[15:8]) & 32'hFFFF) : 32'd0;
		return 16'(sh + 32'd1);
	endfunction

	function automatic logic [15:0] timeout_word(logic [15:0] clocks);
		logic [15:0] man;
		logic [7:0]  ex;
		if (clocks == 16'd0) begin
			return 16'd0;
		end
		man = clocks - 16'd1;
		ex = 8'd0;
		while (man[15:8] != 8'd0) begin
			man = man >> 1;
			ex++;
		end
		return {ex, man[7:0]};
	endfunction

	function automatic tb_budget_types::budget_res_t predict_budget(
		tb_budget_types::budget_req_t r);
		tb_budget_types::budget_res_t o;
		logic [31:0] pre_p, fin_p, step_us, pre_us, fin_us, used;
		logic [15:0] pre_clk, fin_clk, clk16;
		logic        tcc, dss, msrc, pre, fin;
		tcc = r.seq[4];
		dss = r.seq[3];
		msrc = r.seq[2];
		pre = r.seq[6];
		fin = r.seq[7];
		pre_p = pclk_period(r.pre_vcsel);
		fin_p = pclk_period(r.fin_vcsel);
		step_us = clk_to_us(32'(r.msrc_raw) + 32'd1, pre_p);
		pre_clk = timeout_clocks(r.pre_code);
		pre_us = clk_to_us(32'(pre_clk), pre_p);
		fin_clk = timeout_clocks(r.fin_code);
		if (pre) begin
			fin_clk = fin_clk - pre_clk;
		end
		fin_us = clk_to_us(32'(fin_clk), fin_p);
		o.code = 16'd0;
		o.wr = 1'b0;
		o.status = rtc_pkg::StatusOk;
		used = 32'd0;
		if (tcc) begin
			used += step_us + rtc_pkg::TccOvhUs;
		end
		if (dss) begin
			used += 32'd2 * (step_us + rtc_pkg::DssOvhUs);
		end else if (msrc) begin
			used += step_us + rtc_pkg::MsrcOvhUs;
		end
		if (pre) begin
			used += pre_us + rtc_pkg::PreOvhUs;
		end
		o.total = used + rtc_pkg::StartEndUs;
		if (fin) begin
			o.total += fin_us + rtc_pkg::FinalOvhUs;
		end
		used += rtc_pkg::SetStartUs;
		if (r.req < rtc_pkg::MinBudgetUs) begin
			o.status = rtc_pkg::StatusBelow;
		end else if (fin) begin
			used += rtc_pkg::FinalOvhUs;
			if (used > r.req) begin
				o.status = rtc_pkg::StatusNoRoom;
			end else begin
				clk16 = 16'(us_to_clk(r.req - used, fin_p));
				if (pre) begin
					clk16 = clk16 + pre_clk;
				end
				o.code = timeout_word(clk16);
				o.wr = 1'b1;
			end
		end
		return o;
	endfunction

	function automatic tb_budget_types::budget_req_t random_request();
		tb_budget_types::budget_req_t r;
		r.seq = 8'($urandom);
		r.msrc_raw = 8'($urandom);
		r.pre_code = ($urandom_range(0, 7) == 0) ? 16'($urandom)
			: {8'($urandom_range(0, 9)), 8'($urandom)};
		r.fin_code = ($urandom_range(0, 7) == 0) ? 16'($urandom)
			: {8'($urandom_range(0, 12)), 8'($urandom)};
		r.pre_vcsel = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(5, 9));
		r.fin_vcsel = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(3, 7));
		case ($urandom_range(0, 3))
			0: r.req = $urandom;
			1: r.req = $urandom_range(0, 25000);
			default: r.req = $urandom_range(15000, 300000);
		endcase
		return r;
	endfunction

	task automatic send_request(tb_budget_types::budget_req_t r, logic has_exp,
		tb_budget_types::budget_res_t ex);
		while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
			item.valid <= 1'b0;
			@(negedge clk);
		end
		item.valid <= 1'b1;
		item.step_enables <= r.seq;
		item.msrc_timeout_raw <= r.msrc_raw;
		item.pre_range_timeout_code <= r.pre_code;
		item.final_range_timeout_code <= r.fin_code;
		item.pre_vcsel_raw <= r.pre_vcsel;
		item.final_vcsel_raw <= r.fin_vcsel;
		item.requested_budget_us <= r.req;
		expected_q = {expected_q, predict_budget(r)};
		typed_q = {typed_q, ex};
		typed_has_q = {typed_has_q, has_exp};
		do begin
			@(posedge clk);
		end while (!item.ready);
		@(negedge clk);
	endtask

	initial begin
		item.valid = 1'b0;
		item.step_enables = '0;
		item.msrc_timeout_raw = '0;
		item.pre_range_timeout_code = '0;
		item.final_range_timeout_code = '0;
		item.pre_vcsel_raw = '0;
		item.final_vcsel_raw = '0;
		item.requested_budget_us = '0;
		result.ready = 1'b0;
	end

	always @(negedge clk) begin
		result.ready <= !hold_off &&
			!(recv_stall_pct != 0 && $urandom_range(0, 99) < recv_stall_pct);
	end

	always @(posedge clk) begin
		tb_budget_types::budget_res_t e, t;
		logic        th;
		if (arst_n && result.valid && result.ready) begin
			if (expected_q.size() == 0) begin
				$display("%0t unexpected result total=%0d", $time, result.current_budget_us);
				failed = 1'b1;
			end else begin
				e = expected_q.pop_front();
				t = typed_q.pop_front();
				th = typed_has_q.pop_front();
				if (th && t != e) begin
					$display("%0t table row disagrees: typed %p predicted %p", $time, t, e);
					failed = 1'b1;
				end
				if (result.current_budget_us !== e.total) begin
					$display("%0t total expected %0d actual %0d", $time, e.total,
						result.current_budget_us);
					failed = 1'b1;
				end
				if (result.new_final_code !== e.code) begin
					$display("%0t code expected %h actual %h", $time, e.code,
						result.new_final_code);
					failed = 1'b1;
				end
				if (result.write_final !== e.wr) begin
					$display("%0t write expected %b actual %b", $time, e.wr,
						result.write_final);
					failed = 1'b1;
				end
				if (result.set_status !== e.status) begin
					$display("%0t status expected %0d actual %0d", $time, e.status,
						result.set_status);
					failed = 1'b1;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((item.valid && item.ready) || (result.valid && result.ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles >= 20000) begin
			$display("tb: failure");
			$finish;
		end
	end

	tb_budget_types::budget_row_t rows[$];

	function automatic tb_budget_types::budget_row_t mk(logic [7:0] s, logic [7:0] m,
		logic [15:0] pc, logic [15:0] fc, logic [7:0] pv, logic [7:0] fv, logic [31:0] rq,
		logic h, logic [31:0] tot, logic [15:0] cd, logic w, logic [1:0] st);
		tb_budget_types::budget_row_t row;
		row.rq = '{s, m, pc, fc, pv, fv, rq};
		row.has_exp = h;
		row.ex = '{tot, cd, w, st};
		return row;
	endfunction

	initial begin
		tb_budget_types::budget_req_t r;
		tb_budget_types::budget_res_t none;
		int unsigned phase_pct[4][2] = '{'{0, 0}, '{46, 0}, '{0, 46}, '{34, 34}};
		none = '{32'd0, 16'd0, 1'b0, rtc_pkg::StatusOk};
		// Nothing enabled: only start and end overheads; budgets below, at and above the minimum.
		rows = {rows, mk(8'h00, 8'h00, 16'h0000, 16'h0000, 8'h00, 8'h00, 32'd0,
			1, 32'd2870, 16'd0, 0, rtc_pkg::StatusBelow)};
		rows = {rows, mk(8'h00, 8'hFF, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF, 32'hFFFF_FFFF,
			1, 32'd2870, 16'd0, 0, rtc_pkg::StatusOk)};
		rows = {rows, mk(8'h00, 8'h00, 16'h0000, 16'h0000, 8'h00, 8'h00, 32'd19999,
			1, 32'd2870, 16'd0, 0, rtc_pkg::StatusBelow)};
		rows = {rows, mk(8'h00, 8'h00, 16'h0000, 16'h0000, 8'h00, 8'h00, 32'd20000,
			1, 32'd2870, 16'd0, 0, rtc_pkg::StatusOk)};
		// Period overflow on one or both sides: zero macro period, all-ones quotient.
		rows = {rows, mk(8'hFF, 8'hFF, 16'h1234, 16'h0567, 8'd127, 8'd255, 32'd30000,
			0, 0, 0, 0, 0)};
		rows = {rows, mk(8'h80, 8'h00, 16'h0000, 16'h0000, 8'd7, 8'd255, 32'd20000,
			0, 0, 0, 0, 0)};
		rows = {rows, mk(8'hC0, 8'h10, 16'h0010, 16'h0000, 8'd255, 8'd127, 32'd25000,
			0, 0, 0, 0, 0)};
		// Large exponents, wrap of the decoded count, pre larger than final.
		rows = {rows, mk(8'hC0, 8'h20, 16'h10FF, 16'hFFFF, 8'd7, 8'd5, 32'd40000,
			0, 0, 0, 0, 0)};
		rows = {rows, mk(8'hC0, 8'h20, 16'h08FF, 16'h0810, 8'd7, 8'd5, 32'd40000,
			0, 0, 0, 0, 0)};
		rows = {rows, mk(8'hC0, 8'h20, 16'h0FFF, 16'h0F80, 8'd9, 8'd7, 32'd100000,
			0, 0, 0, 0, 0)};
		// No room for the steps.
		rows = {rows, mk(8'hDC, 8'hFF, 16'h0AFF, 16'h0BFF, 8'd9, 8'd7, 32'd20000,
			0, 0, 0, 0, 0)};
		// Typical settings and bit patterns, several step combinations.
		rows = {rows, mk(8'hE8, 8'd99, 16'h0196, 16'h02A0, 8'd6, 8'd4, 32'd33000,
			0, 0, 0, 0, 0)};
		rows = {rows, mk(8'h94, 8'd40, 16'h0196, 16'h02A0, 8'd6, 8'd4, 32'd33000,
			0, 0, 0, 0, 0)};
		rows = {rows, mk(8'hFC, 8'd40, 16'h0196, 16'h0320, 8'd8, 8'd6, 32'd200000,
			0, 0, 0, 0, 0)};
		rows = {rows, mk(8'h84, 8'd0, 16'h0000, 16'h0001, 8'd6, 8'd4, 32'hFFFF_FFFF,
			0, 0, 0, 0, 0)};
		rows = {rows, mk(8'h80, 8'd0, 16'h0000, 16'h0001, 8'd6, 8'd4, 32'd23831,
			0, 0, 0, 0, 0)};
		rows = {rows, mk(8'h5C, 8'hAA, 16'h5555, 16'hAAAA, 8'h55, 8'hAA, 32'h5555_5555,
			0, 0, 0, 0, 0)};
		rows = {rows, mk(8'h23, 8'h55, 16'hAAAA, 16'h5555, 8'hAA, 8'h55, 32'hAAAA_AAAA,
			0, 0, 0, 0, 0)};

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (rows[i]) begin
			send_request(rows[i].rq, rows[i].has_exp, rows[i].has_exp ? rows[i].ex : none);
		end

		for (int p = 0; p < 4; p++) begin
			send_idle_pct = phase_pct[p][0];
			recv_stall_pct = phase_pct[p][1];
			repeat (180) begin
				r = random_request();
				if ($urandom_range(0, 2) != 0) begin
					r.seq[7] = 1'b1;
				end
				send_request(r, 1'b0, none);
			end
		end

		// Long receiver hold-off while requests keep coming, to fill the pipeline.
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_off = 1'b1;
		fork
			begin
				repeat (60) @(negedge clk);
				hold_off = 1'b0;
			end
			repeat (30) send_request(random_request(), 1'b0, none);
		join
		item.valid <= 1'b0;

		for (int k = 0; k < 2000 && expected_q.size() != 0; k++) begin
			@(posedge clk);
		end
		repeat (20) @(posedge clk);
		if (!failed && expected_q.size() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
